/* hdl/wsfp_pkg.sv */
// Shared types and constants for the WebSocket frame parser.
// Used by every module of the parser and by its port checker; no dependencies.

package wsfp_pkg;

    // Parse phases of the receive state machine.
    typedef enum logic [2:0] {
        PH_HEAD = 3'd0,
        PH_LEN  = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    // Frame-end and error events reported with each result.
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_DATA  = 3'd1,
        EV_FRAG  = 3'd2,
        EV_CLOSE = 3'd3,
        EV_PING  = 3'd4,
        EV_PONG  = 3'd5,
        EV_ERR   = 3'd6
    } t_event;

    // Frame opcodes.
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Length codes in the second header byte.
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Extended length byte counts and masking key length.
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

    // Configuration register file.
    localparam int          APB_ADDR_W     = 4;
    localparam int          APB_DATA_W     = 64;
    localparam int          MAX_W          = 63;
    localparam logic        REG_ROLE       = 1'b0;
    localparam logic        REG_MAX        = 1'b1;
    localparam logic [62:0] MAX_RESET      = 63'd65536;

    // Widths of the stream payloads.
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 5;

    typedef struct packed {
        logic              role_is_client;
        logic [MAX_W-1:0]  max_data_payload;
    } t_cfg;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       payload_is_control;
        t_event     event_res;
        logic [3:0] message_opcode;
    } t_result;

endpackage

/* hdl/wsfp_cfg.sv */
// Configuration register file of the WebSocket frame parser behind an APB-style port.
// Depends on wsfp_pkg for the register map and the configuration struct.

module wsfp_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wsfp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [wsfp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [wsfp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output wsfp_pkg::t_cfg                 o_cfg
);
    import wsfp_pkg::*;

    logic             r_role;
    logic [MAX_W-1:0] r_max;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    // Registers sit eight bytes apart; the low address bits are not decoded.
    assign reg_sel = paddr[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role <= 1'b0;
            r_max  <= MAX_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_ROLE: begin
                    r_role <= pwdata[0];
                end
                REG_MAX: begin
                    // A maximum of zero would reject every non-empty data frame, so it is ignored.
                    if (pwdata[MAX_W-1:0] != '0) begin
                        r_max <= pwdata[MAX_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ROLE: prdata = {{(APB_DATA_W-1){1'b0}}, r_role};
            REG_MAX:  prdata = {{(APB_DATA_W-MAX_W){1'b0}}, r_max};
            default:  prdata = '0;
        endcase
    end

    assign o_cfg.role_is_client   = r_role;
    assign o_cfg.max_data_payload = r_max;

endmodule

/* hdl/wsfp_core.sv */
// Frame parser state and the per-byte parse step of the WebSocket frame parser.
// Depends on wsfp_pkg for phases, events, opcodes and the result struct.

module wsfp_core #(
    parameter int LENGTH_BITS = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  wsfp_pkg::t_cfg    i_cfg,
    output wsfp_pkg::t_result o_res
);
    import wsfp_pkg::*;

    localparam int LB = LENGTH_BITS;

    t_phase          r_phase,        n_phase;
    logic [3:0]      r_hcount,       n_hcount;
    logic [7:0]      r_frame_head,   n_frame_head;
    logic            r_mask_present, n_mask_present;
    logic [LB-1:0]   r_acc,          n_acc;
    logic            r_acc_ovf,      n_acc_ovf;
    logic [LB-1:0]   r_bytes_left,   n_bytes_left;
    logic [31:0]     r_mask_key,     n_mask_key;
    logic [1:0]      r_mask_index,   n_mask_index;
    logic [3:0]      r_frag_opcode,  n_frag_opcode;
    logic            r_frag_open,    n_frag_open;
    logic            r_closed,       n_closed;
    logic            r_error,        n_error;
    logic            r_ext_wide,     n_ext_wide;

    // Frame-end outcome, worked out from the stored header byte.
    t_event     fe_ev;
    logic [3:0] fe_op;
    logic       fe_frag_open;
    logic [3:0] fe_frag_opcode;
    logic       fe_closed;

    always_comb begin
        logic       fin;
        logic [3:0] op;
        logic [3:0] rop;
        logic       ok;
        fin            = r_frame_head[7];
        op             = r_frame_head[3:0];
        rop            = op;
        ok             = 1'b1;
        fe_ev          = EV_ERR;
        fe_op          = 4'd0;
        fe_frag_open   = r_frag_open;
        fe_frag_opcode = r_frag_opcode;
        fe_closed      = 1'b0;
        if (!fin) begin
            if (op != OP_CONT) begin
                if (!r_frag_open) begin
                    fe_frag_open   = 1'b1;
                    fe_frag_opcode = op;
                    fe_ev          = EV_FRAG;
                    fe_op          = op;
                end
            end else if (r_frag_open) begin
                fe_ev = EV_FRAG;
                fe_op = r_frag_opcode;
            end
        end else begin
            if (op == OP_CONT) begin
                if (!r_frag_open) begin
                    ok = 1'b0;
                end else begin
                    rop          = r_frag_opcode;
                    fe_frag_open = 1'b0;
                end
            end else if (!op[3] && r_frag_open) begin
                ok = 1'b0;
            end
            if (ok) begin
                case (rop)
                    OP_TEXT, OP_BINARY: begin
                        fe_ev = EV_DATA;
                        fe_op = rop;
                    end
                    OP_CLOSE: begin
                        fe_ev     = EV_CLOSE;
                        fe_op     = rop;
                        fe_closed = 1'b1;
                    end
                    OP_PING: begin
                        fe_ev = EV_PING;
                        fe_op = rop;
                    end
                    OP_PONG: begin
                        fe_ev = EV_PONG;
                        fe_op = rop;
                    end
                    default: begin
                        fe_ev = EV_ERR;
                        fe_op = 4'd0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        logic [6:0]       code;
        logic             len_known;
        logic             len_ext;
        logic             hdr_done;
        logic             frm_end;
        logic             is_ctrl;
        logic [7:0]       key_byte;
        logic [MAX_W-1:0] len63;

        n_phase        = r_phase;
        n_hcount       = r_hcount;
        n_frame_head   = r_frame_head;
        n_mask_present = r_mask_present;
        n_acc          = r_acc;
        n_acc_ovf      = r_acc_ovf;
        n_bytes_left   = r_bytes_left;
        n_mask_key     = r_mask_key;
        n_mask_index   = r_mask_index;
        n_frag_opcode  = r_frag_opcode;
        n_frag_open    = r_frag_open;
        n_closed       = r_closed;
        n_error        = r_error;
        n_ext_wide     = r_ext_wide;
        o_res          = '0;
        o_res.event_res = EV_NONE;

        code      = i_byte[6:0];
        len_known = 1'b0;
        len_ext   = 1'b0;
        hdr_done  = 1'b0;
        frm_end   = 1'b0;
        is_ctrl   = r_frame_head[3];
        key_byte  = 8'd0;
        len63     = '0;

        if (r_error || r_closed) begin
            o_res.event_res = EV_ERR;
        end else begin
            case (r_phase)
                PH_LEN: begin
                    n_mask_present = i_byte[7];
                    if (is_ctrl && code >= LEN_CODE_EXT16) begin
                        n_error         = 1'b1;
                        o_res.event_res = EV_ERR;
                    end else if (code >= LEN_CODE_EXT16) begin
                        n_ext_wide = (code == LEN_CODE_EXT64);
                        n_hcount   = (code == LEN_CODE_EXT64) ? EXT64_BYTES : EXT16_BYTES;
                        n_acc      = '0;
                        n_acc_ovf  = 1'b0;
                        n_phase    = PH_EXT;
                    end else begin
                        n_acc     = LB'(code);
                        n_acc_ovf = 1'b0;
                        len_known = 1'b1;
                    end
                end
                PH_EXT: begin
                    // Bits shifted out above the length width are kept as a sticky flag.
                    n_acc     = {r_acc[LB-9:0], i_byte};
                    n_acc_ovf = r_acc_ovf | (|r_acc[LB-1:LB-8]);
                    n_hcount  = r_hcount - 4'd1;
                    if (n_hcount == 4'd0) begin
                        len_known = 1'b1;
                        len_ext   = 1'b1;
                    end
                end
                PH_MASK: begin
                    n_mask_key = {r_mask_key[23:0], i_byte};
                    n_hcount   = r_hcount - 4'd1;
                    if (n_hcount == 4'd0) begin
                        hdr_done = 1'b1;
                    end
                end
                PH_DATA: begin
                    if (r_mask_present) begin
                        case (r_mask_index)
                            2'd0:    key_byte = r_mask_key[31:24];
                            2'd1:    key_byte = r_mask_key[23:16];
                            2'd2:    key_byte = r_mask_key[15:8];
                            default: key_byte = r_mask_key[7:0];
                        endcase
                    end
                    n_mask_index             = r_mask_index + 2'd1;
                    o_res.payload_valid      = 1'b1;
                    o_res.payload_byte       = i_byte ^ key_byte;
                    o_res.payload_is_control = is_ctrl;
                    n_bytes_left             = r_bytes_left - LB'(1);
                    if (n_bytes_left == '0) begin
                        frm_end = 1'b1;
                    end
                end
                default: begin
                    n_frame_head = i_byte;
                    n_phase      = PH_LEN;
                    if ((i_byte[6:4] != 3'd0) || (i_byte[3] && !i_byte[7])) begin
                        n_error         = 1'b1;
                        o_res.event_res = EV_ERR;
                    end
                end
            endcase

            if (len_known) begin
                len63 = MAX_W'(n_acc);
                if (len_ext && (r_ext_wide ? (!n_acc_ovf && (n_acc >> 16) == '0)
                                           : (n_acc < LB'(LEN_CODE_EXT16)))) begin
                    n_error         = 1'b1;
                    o_res.event_res = EV_ERR;
                end else if (n_acc_ovf) begin
                    n_error         = 1'b1;
                    o_res.event_res = EV_ERR;
                end else if (!is_ctrl && len63 > i_cfg.max_data_payload) begin
                    n_error         = 1'b1;
                    o_res.event_res = EV_ERR;
                end else if (n_mask_present == i_cfg.role_is_client) begin
                    n_error         = 1'b1;
                    o_res.event_res = EV_ERR;
                end else if (n_mask_present) begin
                    n_phase    = PH_MASK;
                    n_hcount   = MASK_BYTES;
                    n_mask_key = '0;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done) begin
                n_bytes_left = n_acc;
                n_mask_index = 2'd0;
                if (n_acc == '0) begin
                    frm_end = 1'b1;
                end else begin
                    n_phase = PH_DATA;
                end
            end

            if (frm_end) begin
                n_phase              = PH_HEAD;
                n_frag_open          = fe_frag_open;
                n_frag_opcode        = fe_frag_opcode;
                n_closed             = fe_closed;
                n_error              = (fe_ev == EV_ERR);
                o_res.event_res      = fe_ev;
                o_res.message_opcode = fe_op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEAD;
            r_hcount       <= 4'd0;
            r_frame_head   <= 8'd0;
            r_mask_present <= 1'b0;
            r_acc          <= '0;
            r_acc_ovf      <= 1'b0;
            r_bytes_left   <= '0;
            r_mask_key     <= '0;
            r_mask_index   <= 2'd0;
            r_frag_opcode  <= 4'd0;
            r_frag_open    <= 1'b0;
            r_closed       <= 1'b0;
            r_error        <= 1'b0;
            r_ext_wide     <= 1'b0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_hcount       <= n_hcount;
            r_frame_head   <= n_frame_head;
            r_mask_present <= n_mask_present;
            r_acc          <= n_acc;
            r_acc_ovf      <= n_acc_ovf;
            r_bytes_left   <= n_bytes_left;
            r_mask_key     <= n_mask_key;
            r_mask_index   <= n_mask_index;
            r_frag_opcode  <= n_frag_opcode;
            r_frag_open    <= n_frag_open;
            r_closed       <= n_closed;
            r_error        <= n_error;
            r_ext_wide     <= n_ext_wide;
        end
    end

endmodule

/* hdl/websocket_frame_parser_unit.sv */
// WebSocket (RFC 6455) receive frame parser. It takes one received byte per request
// and returns one result per byte: the unmasked payload byte where there is one, and
// the frame-end or error event. A byte is registered on input, parsed by the header
// and unmask logic combinationally and registered on output; the block sustains one
// byte per clock while the result stream is not stalled, and the output register and
// the input register together let a new byte enter while a finished result waits.
// Protocol errors and a received close make every later byte report an error until
// reset. The user must write configuration only while no byte is in flight;
// the block does not enforce it. Depends on wsfp_pkg, wsfp_cfg and wsfp_core.

module websocket_frame_parser_unit #(
    parameter int LENGTH_BITS = 63
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Received stream. tdata [7:0] rx_byte.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,
    // Results. tdata [7:0] payload_byte, [11:8] message_opcode, [15:12] zero.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [wsfp_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // tuser [0] payload_valid, [1] payload_is_control, [4:2] event_res.
    output logic [wsfp_pkg::M_TUSER_W-1:0]  o_m_axis_tuser,
    // Configuration: role_is_client at 0x0, max_data_payload at 0x8.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wsfp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [wsfp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [wsfp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import wsfp_pkg::*;

    t_cfg       cfg;
    t_result    step_res;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       step;

    // The parse step fires when a byte is held and the result register is free.
    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    wsfp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wsfp_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out.message_opcode, r_out.payload_byte};
    assign o_m_axis_tuser  = {r_out.event_res, r_out.payload_is_control, r_out.payload_valid};

endmodule

/* hdl/wsfp_checker.sv */
// Port-level checks for the WebSocket frame parser, attached to the top level by bind.
// Depends on wsfp_pkg for the event codes and the stream widths.

module wsfp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [wsfp_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input logic [wsfp_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);
    import wsfp_pkg::*;

    logic [2:0] ev;
    logic       pv;
    assign ev = o_m_axis_tuser[4:2];
    assign pv = o_m_axis_tuser[0];

    // A stalled result holds still.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result pending right after reset");

    // Without a payload byte the byte and control fields are zero.
    a_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !pv |-> o_m_axis_tdata[7:0] == 8'd0 && !o_m_axis_tuser[1])
        else $error("payload fields set without a payload byte");

    // No opcode accompanies an empty or error event.
    a_opcode_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (ev == EV_NONE || ev == EV_ERR) |-> o_m_axis_tdata[11:8] == 4'd0)
        else $error("opcode reported without a frame event");

    // After an error or a close is taken, a result that follows straight after it is an error.
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && (ev == EV_ERR || ev == EV_CLOSE) |=>
            !o_m_axis_tvalid || ev == EV_ERR)
        else $error("result after error or close is not an error");

endmodule

bind websocket_frame_parser_unit wsfp_checker u_wsfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
